FILE: rtl/core/civ_cfe_pkg.sv
// Shared types, frame constants and the BCD conversion step for the
// command frame encoder. No dependencies.
package civ_cfe_pkg;

	// Command kinds carried in the func field
	typedef enum logic [1:0] {
		FUNC_PTT    = 2'd0,
		FUNC_FREQ   = 2'd1,
		FUNC_MODE   = 2'd2,
		FUNC_UNUSED = 2'd3
	} func_t;

	// Fixed frame bytes
	localparam logic [7:0] PREAMBLE_BYTE   = 8'hFE;
	localparam logic [7:0] CONTROLLER_BYTE = 8'hE0;
	localparam logic [7:0] END_BYTE        = 8'hFD;
	localparam logic [7:0] CMD_PTT         = 8'h1C;
	localparam logic [7:0] SUB_PTT         = 8'h00;
	localparam logic [7:0] CMD_FREQ        = 8'h05;
	localparam logic [7:0] CMD_MODE        = 8'h06;
	localparam logic [7:0] FILTER_NORMAL   = 8'h01;
	localparam logic [7:0] PTT_TX          = 8'h01;
	localparam logic [7:0] PTT_RX          = 8'h00;

	// Binary to BCD conversion geometry
	localparam int BIN_W          = 32;
	localparam int BCD_DIGITS     = 10;
	localparam int BCD_W          = 4 * BCD_DIGITS;
	localparam int STEPS_PER_STG  = 8;
	localparam int NUM_BCD_STAGES = BIN_W / STEPS_PER_STG;

	// Byte index within a frame
	localparam int POS_W = 4;
	localparam logic [POS_W-1:0] POS_PRE0      = 4'd0;
	localparam logic [POS_W-1:0] POS_PRE1      = 4'd1;
	localparam logic [POS_W-1:0] POS_ADDR      = 4'd2;
	localparam logic [POS_W-1:0] POS_CTRL      = 4'd3;
	localparam logic [POS_W-1:0] POS_CMD       = 4'd4;
	localparam logic [POS_W-1:0] POS_DATA0     = 4'd5;
	localparam logic [POS_W-1:0] POS_DATA1     = 4'd6;
	localparam logic [POS_W-1:0] POS_DATA2     = 4'd7;
	localparam logic [POS_W-1:0] POS_DATA3     = 4'd8;
	localparam logic [POS_W-1:0] POS_DATA4     = 4'd9;
	localparam logic [POS_W-1:0] POS_LAST_FREQ = 4'd10;
	localparam logic [POS_W-1:0] POS_LAST_SHORT = 4'd7;

	// One command as it travels down the pipeline
	typedef struct packed {
		func_t              func;
		logic               transmit_on;
		logic [7:0]         mode_code;
		logic [BIN_W-1:0]   bin;
		logic [BCD_W-1:0]   bcd;
	} item_t;

	// Run a slice of shift-and-add-3 steps, consuming binary bits MSB first
	function automatic item_t bcd_steps(item_t it);
		item_t r;
		r = it;
		for (int s = 0; s < STEPS_PER_STG; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (r.bcd[4*d +: 4] >= 4'd5) begin
					r.bcd[4*d +: 4] = r.bcd[4*d +: 4] + 4'd3;
				end
			end
			r.bcd = {r.bcd[BCD_W-2:0], r.bin[BIN_W-1]};
			r.bin = {r.bin[BIN_W-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/civ_cfe_bcd_stage.sv
// One pipeline stage of the binary to BCD converter with valid/ready flow.
// Depends on civ_cfe_pkg for the item type and the conversion step.
module civ_cfe_bcd_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  civ_cfe_pkg::item_t in_item,
	output logic               in_ready,
	output logic               out_valid,
	output civ_cfe_pkg::item_t out_item,
	input  logic               out_ready
);

	logic               valid_q;
	civ_cfe_pkg::item_t item_q;

	// Advance when the stage is empty or its content moves on
	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	// Load the next conversion slice on a transfer
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= civ_cfe_pkg::bcd_steps(in_item);
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: rtl/core/civ_command_frame_encoder_unit.sv
// Command frame encoder: four BCD conversion stages, a frame serializer and
// an output register. Uses civ_cfe_pkg and civ_cfe_bcd_stage.
// A command passes through the four conversion stages, the frame register
// and the output register. Throughput: one byte per cycle while byte_stall is
// low; a frame is 8 bytes (push-to-talk, set mode) or 11 bytes (set frequency).
// Reset: arst_n clears all valid state and target address to 0.
module civ_command_frame_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	// command channel
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic [1:0] func,
	input  logic       transmit_on,
	input  logic [31:0] frequency_hz,
	input  logic [7:0] mode_code,
	// byte channel
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] frame_byte,
	output logic       end_of_frame,
	// configuration
	input  logic       target_address_we,
	input  logic [7:0] target_address_data
);

	localparam int NS = civ_cfe_pkg::NUM_BCD_STAGES;

	logic                       stg_valid [NS+1];
	logic                       stg_ready [NS+1];
	civ_cfe_pkg::item_t         stg_item  [NS+1];

	logic [7:0]                 target_address_q;
	logic                       busy_q;
	civ_cfe_pkg::item_t         frm_q;
	logic [civ_cfe_pkg::POS_W-1:0] pos_q;
	logic                       byte_valid_q;
	logic [7:0]                 frame_byte_q;
	logic                       end_of_frame_q;

	logic                       emit;
	logic                       last;
	logic                       ser_ready;
	logic                       take;
	logic [7:0]                 sel_byte;

	// Hold the radio address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_address_q <= 8'h00;
		end else if (target_address_we) begin
			target_address_q <= target_address_data;
		end
	end

	// Enter commands; drop the unused kind at the input
	assign stg_valid[0] = cmd_valid && (civ_cfe_pkg::func_t'(func) != civ_cfe_pkg::FUNC_UNUSED);
	assign stg_item[0]  = '{func:        civ_cfe_pkg::func_t'(func),
	                        transmit_on: transmit_on,
	                        mode_code:   mode_code,
	                        bin:         frequency_hz,
	                        bcd:         '0};
	assign cmd_stall = !stg_ready[0];

	// Conversion pipeline
	for (genvar g = 0; g < NS; g++) begin : g_bcd
		civ_cfe_bcd_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (stg_valid[g]),
			.in_item  (stg_item[g]),
			.in_ready (stg_ready[g]),
			.out_valid(stg_valid[g+1]),
			.out_item (stg_item[g+1]),
			.out_ready(stg_ready[g+1])
		);
	end

	// Serializer handshake
	assign emit = busy_q && (!byte_valid_q || !byte_stall);
	assign last = (frm_q.func == civ_cfe_pkg::FUNC_FREQ) ?
	              (pos_q == civ_cfe_pkg::POS_LAST_FREQ) :
	              (pos_q == civ_cfe_pkg::POS_LAST_SHORT);
	assign ser_ready    = !busy_q || (emit && last);
	assign stg_ready[NS] = ser_ready;
	assign take         = stg_valid[NS] && ser_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (emit && last) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frm_q <= stg_item[NS];
		end
	end

	// Select the frame byte at the current position
	always_comb begin
		sel_byte = civ_cfe_pkg::END_BYTE;
		unique case (pos_q)
			civ_cfe_pkg::POS_PRE0,
			civ_cfe_pkg::POS_PRE1: sel_byte = civ_cfe_pkg::PREAMBLE_BYTE;
			civ_cfe_pkg::POS_ADDR: sel_byte = target_address_q;
			civ_cfe_pkg::POS_CTRL: sel_byte = civ_cfe_pkg::CONTROLLER_BYTE;
			civ_cfe_pkg::POS_CMD: begin
				unique case (frm_q.func)
					civ_cfe_pkg::FUNC_PTT:  sel_byte = civ_cfe_pkg::CMD_PTT;
					civ_cfe_pkg::FUNC_FREQ: sel_byte = civ_cfe_pkg::CMD_FREQ;
					default:                sel_byte = civ_cfe_pkg::CMD_MODE;
				endcase
			end
			civ_cfe_pkg::POS_DATA0: begin
				unique case (frm_q.func)
					civ_cfe_pkg::FUNC_PTT:  sel_byte = civ_cfe_pkg::SUB_PTT;
					civ_cfe_pkg::FUNC_FREQ: sel_byte = frm_q.bcd[7:0];
					default:                sel_byte = frm_q.mode_code;
				endcase
			end
			civ_cfe_pkg::POS_DATA1: begin
				unique case (frm_q.func)
					civ_cfe_pkg::FUNC_PTT: sel_byte = frm_q.transmit_on ?
					                                  civ_cfe_pkg::PTT_TX : civ_cfe_pkg::PTT_RX;
					civ_cfe_pkg::FUNC_FREQ: sel_byte = frm_q.bcd[15:8];
					default:                sel_byte = civ_cfe_pkg::FILTER_NORMAL;
				endcase
			end
			civ_cfe_pkg::POS_DATA2: begin
				sel_byte = (frm_q.func == civ_cfe_pkg::FUNC_FREQ) ?
				           frm_q.bcd[23:16] : civ_cfe_pkg::END_BYTE;
			end
			civ_cfe_pkg::POS_DATA3: sel_byte = frm_q.bcd[31:24];
			civ_cfe_pkg::POS_DATA4: sel_byte = frm_q.bcd[39:32];
			default:                sel_byte = civ_cfe_pkg::END_BYTE;
		endcase
	end

	// Output register: load on emit, drop after a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_q <= 1'b0;
		end else if (emit) begin
			byte_valid_q <= 1'b1;
		end else if (!byte_stall) begin
			byte_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			frame_byte_q   <= sel_byte;
			end_of_frame_q <= last;
		end
	end

	assign byte_valid   = byte_valid_q;
	assign frame_byte   = frame_byte_q;
	assign end_of_frame = end_of_frame_q;

endmodule

FILE: sim/civ_cfe_frame_checker.sv
// Frame checker for the command frame encoder: watches both channels, predicts
// every frame byte and compares it against the byte stream.
// Depends on civ_cfe_pkg for the command kinds and fixed frame bytes.
module civ_cfe_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [1:0]  func,
	input  logic        transmit_on,
	input  logic [31:0] frequency_hz,
	input  logic [7:0]  mode_code,
	input  logic        byte_valid,
	input  logic        byte_stall,
	input  logic [7:0]  frame_byte,
	input  logic        end_of_frame,
	input  logic        target_address_we,
	input  logic [7:0]  target_address_data,
	output int          mismatch_count,
	output int          frame_bytes_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
	} frame_entry_t;

	// Bytes still owed by the encoder, oldest first
	frame_entry_t frame_bytes_q[$];
	logic [7:0]   radio_address;

	// Ten decimal digits, digit 0 in the low nibble
	function automatic logic [39:0] hz_to_digits(logic [31:0] hz);
		logic [39:0] digits;
		logic [31:0] rest;
		digits = '0;
		rest = hz;
		for (int d = 0; d < 10; d++) begin
			digits[4*d +: 4] = 4'(rest % 32'd10);
			rest = rest / 32'd10;
		end
		return digits;
	endfunction

	// Wrap a command body (byte 0 in the low bits) in header and trailer
	task automatic queue_frame(input logic [47:0] body, input int body_len);
		frame_bytes_q.push_back('{value: civ_cfe_pkg::PREAMBLE_BYTE, last: 1'b0});
		frame_bytes_q.push_back('{value: civ_cfe_pkg::PREAMBLE_BYTE, last: 1'b0});
		frame_bytes_q.push_back('{value: radio_address, last: 1'b0});
		frame_bytes_q.push_back('{value: civ_cfe_pkg::CONTROLLER_BYTE, last: 1'b0});
		for (int i = 0; i < body_len; i++) begin
			frame_bytes_q.push_back('{value: body[8*i +: 8], last: 1'b0});
		end
		frame_bytes_q.push_back('{value: civ_cfe_pkg::END_BYTE, last: 1'b1});
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_entry_t want;
		if (!arst_n) begin
			frame_bytes_q.delete();
			radio_address = '0;
			mismatch_count = 0;
			frame_bytes_due <= 0;
		end else begin
			// Compare each byte transfer with the oldest owed byte
			if (byte_valid && !byte_stall) begin
				if (frame_bytes_q.size() == 0) begin
					$error("frame_byte: unexpected transfer, actual %02h", frame_byte);
					mismatch_count++;
				end else begin
					want = frame_bytes_q.pop_front();
					if (frame_byte !== want.value) begin
						$error("frame_byte: expected %02h, actual %02h",
							want.value, frame_byte);
						mismatch_count++;
					end
					if (end_of_frame !== want.last) begin
						$error("end_of_frame: expected %0b, actual %0b",
							want.last, end_of_frame);
						mismatch_count++;
					end
				end
			end

			// Track the radio address register
			if (target_address_we) begin
				radio_address = target_address_data;
			end

			// Predict the frame of each command transfer
			if (cmd_valid && !cmd_stall) begin
				case (civ_cfe_pkg::func_t'(func))
					civ_cfe_pkg::FUNC_PTT: begin
						queue_frame({24'h0,
							transmit_on ? civ_cfe_pkg::PTT_TX : civ_cfe_pkg::PTT_RX,
							civ_cfe_pkg::SUB_PTT, civ_cfe_pkg::CMD_PTT}, 3);
					end
					civ_cfe_pkg::FUNC_FREQ: begin
						queue_frame({hz_to_digits(frequency_hz), civ_cfe_pkg::CMD_FREQ}, 6);
					end
					civ_cfe_pkg::FUNC_MODE: begin
						queue_frame({24'h0, civ_cfe_pkg::FILTER_NORMAL, mode_code,
							civ_cfe_pkg::CMD_MODE}, 3);
					end
					default: begin
						// unused command kind: no frame
					end
				endcase
			end

			frame_bytes_due <= frame_bytes_q.size();
		end
	end

endmodule

FILE: sim/civ_command_frame_encoder_unit_test.sv
// Testbench top for the command frame encoder: clock, reset, command and
// stall stimulus, watchdog and verdict. Depends on civ_cfe_pkg, the encoder
// RTL and civ_cfe_frame_checker.
module civ_command_frame_encoder_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int FLUSH_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEMS_PER_PHASE = 117;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  func = civ_cfe_pkg::FUNC_PTT;
	logic        transmit_on = 1'b0;
	logic [31:0] frequency_hz = '0;
	logic [7:0]  mode_code = '0;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  frame_byte;
	logic        end_of_frame;
	logic        target_address_we = 1'b0;
	logic [7:0]  target_address_data = '0;
	int          mismatch_count;
	int          frame_bytes_due;

	int          sender_idle_pct = 0;
	int          receiver_idle_pct = 0;
	bit          long_hold_req = 1'b0;
	int          stuck_cycles = 0;

	civ_command_frame_encoder_unit dut (.*);

	civ_cfe_frame_checker frame_check (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Receiver: random stall, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				byte_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			byte_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	initial begin
		while (stuck_cycles < STUCK_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_valid && !cmd_stall) || (byte_valid && !byte_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
			end
		end
		$display("civ_command_frame_encoder_unit_test: FAIL");
		$finish;
	end

	// Offer one command after a random gap and hold it until transferred
	task automatic offer_command(input logic [1:0] f, input logic on,
			input logic [31:0] hz, input logic [7:0] mode);
		while ($urandom_range(99) < sender_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		func <= f;
		transmit_on <= on;
		frequency_hz <= hz;
		mode_code <= mode;
		do @(posedge clk); while (cmd_stall);
	endtask

	// Stop offering and wait until every owed byte is out and the pipe is empty
	task automatic drain_frames();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (frame_bytes_due != 0);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic write_radio_address(input logic [7:0] addr);
		target_address_we <= 1'b1;
		target_address_data <= addr;
		@(posedge clk);
		target_address_we <= 1'b0;
	endtask

	// Mostly valid commands with varied frequencies, some unused kinds
	task automatic offer_random_command();
		logic [1:0]  f;
		logic [31:0] hz;
		logic [31:0] decade;
		int          pick;
		f = ($urandom_range(99) < 8) ? civ_cfe_pkg::FUNC_UNUSED : 2'($urandom_range(2));
		pick = $urandom_range(4);
		case (pick)
			0: hz = $urandom;
			1: hz = $urandom_range(999);
			2: hz = $urandom_range(450_000_000, 1_800_000);
			3: begin
				decade = 32'd1;
				repeat ($urandom_range(9)) decade = decade * 32'd10;
				hz = decade - 32'($urandom_range(1));
			end
			default: hz = 32'hFFFF_FFFF - 32'($urandom_range(100_000));
		endcase
		offer_command(f, 1'($urandom_range(1)), hz, 8'($urandom_range(255)));
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed commands at the reset address
		offer_command(civ_cfe_pkg::FUNC_PTT, 1'b1, '0, '0);
		offer_command(civ_cfe_pkg::FUNC_PTT, 1'b0, '0, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'd0, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'hFFFF_FFFF, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'd14_074_000, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'd1_000_000_000, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b1, 32'hAAAA_AAAA, 8'hFF);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'h5555_5555, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'd9, '0);
		offer_command(civ_cfe_pkg::FUNC_MODE, 1'b0, '0, 8'h00);
		offer_command(civ_cfe_pkg::FUNC_MODE, 1'b0, '0, 8'hFF);
		offer_command(civ_cfe_pkg::FUNC_UNUSED, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		offer_command(civ_cfe_pkg::FUNC_PTT, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		offer_command(civ_cfe_pkg::FUNC_UNUSED, 1'b0, '0, '0);
		offer_command(civ_cfe_pkg::FUNC_MODE, 1'b1, 32'h1234_5678, 8'hA5);
		drain_frames();

		// Directed commands at the top address
		write_radio_address(8'hFF);
		offer_command(civ_cfe_pkg::FUNC_PTT, 1'b1, '0, '0);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b0, 32'd999_999_999, '0);
		offer_command(civ_cfe_pkg::FUNC_MODE, 1'b0, '0, 8'h03);
		offer_command(civ_cfe_pkg::FUNC_UNUSED, 1'b1, 32'd7_000_000, 8'h01);
		offer_command(civ_cfe_pkg::FUNC_FREQ, 1'b1, 32'hFFFF_FFFF, 8'h5A);
		drain_frames();

		// Slow sender, mostly stalled receiver; pause mid-phase until drained
		write_radio_address(8'($urandom_range(254, 1)));
		sender_idle_pct = 36;
		receiver_idle_pct = 87;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			if (n == ITEMS_PER_PHASE / 2) begin
				drain_frames();
			end
			offer_random_command();
		end
		drain_frames();

		// Mostly idle sender, lightly stalled receiver
		write_radio_address(8'h00);
		sender_idle_pct = 87;
		receiver_idle_pct = 36;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			offer_random_command();
		end
		drain_frames();

		// No idling; open with a long receiver hold-off to back up the input
		write_radio_address(8'($urandom_range(255)));
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		long_hold_req = 1'b1;
		for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
			offer_random_command();
		end
		drain_frames();

		if (mismatch_count == 0 && frame_bytes_due == 0) begin
			$display("civ_command_frame_encoder_unit_test: PASS");
		end else begin
			$display("civ_command_frame_encoder_unit_test: FAIL");
		end
		$finish;
	end

endmodule
